// ===== design/tbo_pkg.sv =====
// Shared types and constants for the triangle / box overlap test.
// Used by tbo_edge_axis and triangle_box_overlap_test_top.
package tbo_pkg;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } t_cfg_idx;

    // Load enables of the three pipeline stages inside one edge axis unit
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_edge_en;

endpackage

// ===== design/tbo_edge_axis.sv =====
// One edge-cross-box-axis separating test, three register stages.
// Depends on tbo_pkg for the stage enable struct.
module tbo_edge_axis #(
    parameter int COORD_BITS = 20
) (
    input  logic                    i_clk,
    input  tbo_pkg::t_edge_en       i_en,
    input  logic signed [COORD_BITS+2:0] i_a,
    input  logic signed [COORD_BITS+2:0] i_b,
    input  logic        [COORD_BITS+2:0] i_fa,
    input  logic        [COORD_BITS+2:0] i_fb,
    input  logic signed [COORD_BITS:0]   i_ha,
    input  logic signed [COORD_BITS:0]   i_hb,
    input  logic signed [COORD_BITS+1:0] i_vs [3],
    input  logic signed [COORD_BITS+1:0] i_vt [3],
    output logic                    o_sep
);
    import tbo_pkg::*;

    localparam int EW = COORD_BITS + 3;
    localparam int VW = COORD_BITS + 2;
    localparam int HW = COORD_BITS + 1;
    localparam int PW = EW + VW;
    localparam int RW = EW + 1 + HW;
    localparam int CW = 2 * COORD_BITS + 7;

    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] r_pb [3];
    logic signed [RW-1:0] r_ra;
    logic signed [RW-1:0] r_rb;
    logic signed [CW-1:0] r_p [3];
    logic signed [CW-1:0] r_rad;
    logic                 r_sep;
    logic signed [CW-1:0] w_lo;
    logic signed [CW-1:0] w_hi;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= i_a * i_vs[i];
                r_pb[i] <= i_b * i_vt[i];
            end
            r_ra <= $signed({1'b0, i_fa}) * i_ha;
            r_rb <= $signed({1'b0, i_fb}) * i_hb;
        end
        if (i_en.s3) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= CW'(r_pa[i]) - CW'(r_pb[i]);
            end
            r_rad <= CW'(r_ra) + CW'(r_rb);
        end
        if (i_en.s4) begin
            r_sep <= (r_rad < w_lo) || (w_hi < -r_rad);
        end
    end

    always_comb begin
        w_lo = r_p[0];
        w_hi = r_p[0];
        for (int i = 1; i < 3; i++) begin
            if (r_p[i] < w_lo) w_lo = r_p[i];
            if (r_p[i] > w_hi) w_hi = r_p[i];
        end
    end

    assign o_sep = r_sep;

endmodule

// ===== design/triangle_box_overlap_test_top.sv =====
// Triangle / axis-aligned box overlap test, seven-stage pipeline.
// Depends on tbo_pkg and tbo_edge_axis.
//
// Usage:
//   The box bounds are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while no transaction is in flight; writes take effect at once.
//   A transaction on the input channel carries three triangle vertices and
//   is taken when i_valid is high and o_stall is low. Each one yields
//   exactly one output transaction with o_overlap (1 = touch or overlap).
// Path: with no stall a transaction passes seven register stages, the first
//   loaded at the accepting edge; o_valid comes from the seventh.
// Throughput: one triangle per cycle while i_stall is low; set by the pipeline, whose widest
//   step is the 25 x 22 bit low half of the split plane-normal multiply.
// Stages, in order: doubled vertices and edges; edge and normal products
//   plus box-axis test; projection differences and plane normal; edge-axis
//   decision and split normal products; product recombination; plane sums;
//   plane decision and result register.
// Reset: synchronous, active low; clears all stage valid bits and sets
//   every box bound to 0.
// Stall: each full stage holds while the one after it is held, so
//   bubbles are squeezed out; o_stall rises only with all stages full
//   and i_stall high.
module triangle_box_overlap_test_top #(
    parameter int COORD_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tbo_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic signed [COORD_BITS-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_vert0_x,
    input  logic signed [COORD_BITS-1:0]  i_vert0_y,
    input  logic signed [COORD_BITS-1:0]  i_vert0_z,
    input  logic signed [COORD_BITS-1:0]  i_vert1_x,
    input  logic signed [COORD_BITS-1:0]  i_vert1_y,
    input  logic signed [COORD_BITS-1:0]  i_vert1_z,
    input  logic signed [COORD_BITS-1:0]  i_vert2_x,
    input  logic signed [COORD_BITS-1:0]  i_vert2_y,
    input  logic signed [COORD_BITS-1:0]  i_vert2_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_overlap
);
    import tbo_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int EW  = C + 3;
    localparam int VW  = C + 2;
    localparam int HW  = C + 1;
    localparam int MW  = 2 * EW;
    localparam int NW  = MW + 1;
    localparam int SH  = C + 4;
    localparam int NHW = NW - SH;
    localparam int DW  = 3 * C + 12;

    logic signed [C-1:0] r_box_min [3];
    logic signed [C-1:0] r_box_max [3];

    logic [7:1] r_vld;
    logic [8:1] w_en;

    logic signed [C-1:0]  w_p [3][3];
    logic signed [VW-1:0] n_s1_v [3][3];
    logic signed [EW-1:0] n_s1_e [3][3];
    logic signed [HW-1:0] n_s1_h [3];
    logic signed [VW-1:0] r_s1_v [3][3];
    logic signed [EW-1:0] r_s1_e [3][3];
    logic signed [HW-1:0] r_s1_h [3];
    logic        [EW-1:0] w_f [3][3];

    logic                 n_s2_box;
    logic                 r_s2_box;
    logic signed [MW-1:0] r_s2_m [3][2];
    logic signed [VW-1:0] r_s2_v0 [3];
    logic signed [HW-1:0] r_s2_h [3];

    logic                 r_s3_box;
    logic signed [NW-1:0] r_s3_n [3];
    logic signed [VW-1:0] r_s3_v0 [3];
    logic signed [HW-1:0] r_s3_h [3];

    logic                 r_s4_box;
    logic signed [SH+VW:0]    r_s4_dlo [3];
    logic signed [NHW+VW-1:0] r_s4_dhi [3];
    logic signed [SH+HW:0]    r_s4_rlo [3];
    logic signed [NHW+HW-1:0] r_s4_rhi [3];
    logic        [2:0]        r_s4_neg;

    logic                 w_edge_sep [3][3];
    logic                 w_edge_any;
    logic                 r_s5_sep;
    logic signed [DW-1:0] r_s5_d [3];
    logic signed [DW-1:0] r_s5_r [3];
    logic        [2:0]    r_s5_neg;

    logic                 r_s6_sep;
    logic signed [DW-1:0] r_s6_d;
    logic signed [DW-1:0] r_s6_rad;

    logic                 r_s7_ovl;

    t_edge_en             w_edge_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < 3; q++) begin
                r_box_min[q] <= '0;
                r_box_max[q] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_MIN_X: r_box_min[0] <= i_cfg_data;
                CFG_BOX_MIN_Y: r_box_min[1] <= i_cfg_data;
                CFG_BOX_MIN_Z: r_box_min[2] <= i_cfg_data;
                CFG_BOX_MAX_X: r_box_max[0] <= i_cfg_data;
                CFG_BOX_MAX_Y: r_box_max[1] <= i_cfg_data;
                CFG_BOX_MAX_Z: r_box_max[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables
    always_comb begin
        w_en[8] = !i_stall;
        for (int k = 7; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) r_vld[1] <= i_valid;
            for (int k = 2; k <= 7; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: doubled coordinates about the box center
    assign w_p[0][0] = i_vert0_x;
    assign w_p[0][1] = i_vert0_y;
    assign w_p[0][2] = i_vert0_z;
    assign w_p[1][0] = i_vert1_x;
    assign w_p[1][1] = i_vert1_y;
    assign w_p[1][2] = i_vert1_z;
    assign w_p[2][0] = i_vert2_x;
    assign w_p[2][1] = i_vert2_y;
    assign w_p[2][2] = i_vert2_z;

    always_comb begin
        for (int q = 0; q < 3; q++) begin
            n_s1_h[q] = HW'(r_box_max[q]) - HW'(r_box_min[q]);
            for (int i = 0; i < 3; i++) begin
                n_s1_v[i][q] = (VW'(w_p[i][q]) <<< 1) - VW'(r_box_min[q])
                             - VW'(r_box_max[q]);
            end
            n_s1_e[0][q] = (EW'(w_p[1][q]) - EW'(w_p[0][q])) <<< 1;
            n_s1_e[1][q] = (EW'(w_p[2][q]) - EW'(w_p[1][q])) <<< 1;
            n_s1_e[2][q] = (EW'(w_p[0][q]) - EW'(w_p[2][q])) <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_v <= n_s1_v;
            r_s1_e <= n_s1_e;
            r_s1_h <= n_s1_h;
        end
    end

    // stage 2: box-axis test and normal products
    always_comb begin
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] hi;
        n_s2_box = 1'b0;
        for (int q = 0; q < 3; q++) begin
            lo = r_s1_v[0][q];
            hi = r_s1_v[0][q];
            for (int i = 1; i < 3; i++) begin
                if (r_s1_v[i][q] < lo) lo = r_s1_v[i][q];
                if (r_s1_v[i][q] > hi) hi = r_s1_v[i][q];
            end
            if ((lo > VW'(r_s1_h[q])) || (hi < -VW'(r_s1_h[q]))) n_s2_box = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            for (int q = 0; q < 3; q++) begin
                w_f[i][q] = r_s1_e[i][q][EW-1] ? EW'(-r_s1_e[i][q]) : EW'(r_s1_e[i][q]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_box   <= n_s2_box;
            r_s2_m[0][0] <= r_s1_e[0][1] * r_s1_e[1][2];
            r_s2_m[0][1] <= r_s1_e[0][2] * r_s1_e[1][1];
            r_s2_m[1][0] <= r_s1_e[0][2] * r_s1_e[1][0];
            r_s2_m[1][1] <= r_s1_e[0][0] * r_s1_e[1][2];
            r_s2_m[2][0] <= r_s1_e[0][0] * r_s1_e[1][1];
            r_s2_m[2][1] <= r_s1_e[0][1] * r_s1_e[1][0];
            for (int q = 0; q < 3; q++) begin
                r_s2_v0[q] <= r_s1_v[0][q];
                r_s2_h[q]  <= r_s1_h[q];
            end
        end
    end

    // edge-cross-axis tests, stages 2 to 4
    assign w_edge_en = '{s2: w_en[2], s3: w_en[3], s4: w_en[4]};

    for (genvar g = 0; g < 3; g++) begin : g_edge
        logic signed [VW-1:0] w_vx [3];
        logic signed [VW-1:0] w_vy [3];
        logic signed [VW-1:0] w_vz [3];

        for (genvar j = 0; j < 3; j++) begin : g_vert
            assign w_vx[j] = r_s1_v[j][0];
            assign w_vy[j] = r_s1_v[j][1];
            assign w_vz[j] = r_s1_v[j][2];
        end

        tbo_edge_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
            .i_clk (i_clk),
            .i_en  (w_edge_en),
            .i_a   (r_s1_e[g][2]),
            .i_b   (r_s1_e[g][1]),
            .i_fa  (w_f[g][2]),
            .i_fb  (w_f[g][1]),
            .i_ha  (r_s1_h[1]),
            .i_hb  (r_s1_h[2]),
            .i_vs  (w_vy),
            .i_vt  (w_vz),
            .o_sep (w_edge_sep[g][0])
        );

        tbo_edge_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
            .i_clk (i_clk),
            .i_en  (w_edge_en),
            .i_a   (r_s1_e[g][0]),
            .i_b   (r_s1_e[g][2]),
            .i_fa  (w_f[g][2]),
            .i_fb  (w_f[g][0]),
            .i_ha  (r_s1_h[0]),
            .i_hb  (r_s1_h[2]),
            .i_vs  (w_vz),
            .i_vt  (w_vx),
            .o_sep (w_edge_sep[g][1])
        );

        tbo_edge_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
            .i_clk (i_clk),
            .i_en  (w_edge_en),
            .i_a   (r_s1_e[g][1]),
            .i_b   (r_s1_e[g][0]),
            .i_fa  (w_f[g][1]),
            .i_fb  (w_f[g][0]),
            .i_ha  (r_s1_h[0]),
            .i_hb  (r_s1_h[1]),
            .i_vs  (w_vx),
            .i_vt  (w_vy),
            .o_sep (w_edge_sep[g][2])
        );
    end

    always_comb begin
        w_edge_any = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_edge_any = w_edge_any | w_edge_sep[i][j];
            end
        end
    end

    // stage 3: plane normal
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_box <= r_s2_box;
            for (int q = 0; q < 3; q++) begin
                r_s3_n[q]  <= NW'(r_s2_m[q][0]) - NW'(r_s2_m[q][1]);
                r_s3_v0[q] <= r_s2_v0[q];
                r_s3_h[q]  <= r_s2_h[q];
            end
        end
    end

    // stage 4: normal times vertex and half size, split in two halves
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_box <= r_s3_box;
            for (int q = 0; q < 3; q++) begin
                r_s4_dlo[q] <= $signed({1'b0, r_s3_n[q][SH-1:0]}) * r_s3_v0[q];
                r_s4_dhi[q] <= $signed(r_s3_n[q][NW-1:SH]) * r_s3_v0[q];
                r_s4_rlo[q] <= $signed({1'b0, r_s3_n[q][SH-1:0]}) * r_s3_h[q];
                r_s4_rhi[q] <= $signed(r_s3_n[q][NW-1:SH]) * r_s3_h[q];
                r_s4_neg[q] <= r_s3_n[q][NW-1];
            end
        end
    end

    // stage 5: recombine halves
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_sep <= r_s4_box | w_edge_any;
            r_s5_neg <= r_s4_neg;
            for (int q = 0; q < 3; q++) begin
                r_s5_d[q] <= (DW'(r_s4_dhi[q]) <<< SH) + DW'(r_s4_dlo[q]);
                r_s5_r[q] <= (DW'(r_s4_rhi[q]) <<< SH) + DW'(r_s4_rlo[q]);
            end
        end
    end

    // stage 6: plane offset and radius
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_sep <= r_s5_sep;
            r_s6_d   <= r_s5_d[0] + r_s5_d[1] + r_s5_d[2];
            r_s6_rad <= (r_s5_neg[0] ? -r_s5_r[0] : r_s5_r[0])
                      + (r_s5_neg[1] ? -r_s5_r[1] : r_s5_r[1])
                      + (r_s5_neg[2] ? -r_s5_r[2] : r_s5_r[2]);
        end
    end

    // stage 7: plane decision
    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s7_ovl <= !(r_s6_sep || (r_s6_d < -r_s6_rad) || (r_s6_rad < r_s6_d));
        end
    end

    assign o_valid   = r_vld[7];
    assign o_overlap = r_s7_ovl;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with a free stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[1])
        else $error("accepted transaction missing from stage 1");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[7] && i_stall) |=> (r_vld[7] && $stable(r_s7_ovl)))
        else $error("held result changed");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && r_vld[7] && i_stall) |=> r_vld[6])
        else $error("stage 6 transaction lost under stall");

endmodule
